[src/slst_pkg.sv]
package slst_pkg;

  // Coordinates and scissor bounds are 12-bit two's complement.
  typedef logic signed [11:0] coord_t;
  typedef logic [11:0]        len_t;
  typedef logic [1:0]         dir_t;

  // Display size used by the trivial-reject test.
  localparam coord_t DISPLAY_W = 12'sd640;
  localparam coord_t DISPLAY_H = 12'sd480;

  // Alpha value that means an opaque write.
  localparam logic [7:0] OPAQUE = 8'd255;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Direction codes: two's complement -1, 0, +1.
  localparam dir_t DIR_ZERO = 2'd0;
  localparam dir_t DIR_POS  = 2'd1;
  localparam dir_t DIR_NEG  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCISSOR_LEFT   = 2'd0;
  localparam logic [1:0] CFG_SCISSOR_TOP    = 2'd1;
  localparam logic [1:0] CFG_SCISSOR_RIGHT  = 2'd2;
  localparam logic [1:0] CFG_SCISSOR_BOTTOM = 2'd3;

  // Scissor reset values.
  localparam coord_t SCISSOR_LEFT_RST   = 12'sd0;
  localparam coord_t SCISSOR_TOP_RST    = 12'sd0;
  localparam coord_t SCISSOR_RIGHT_RST  = 12'sd640;
  localparam coord_t SCISSOR_BOTTOM_RST = 12'sd480;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // One input item.
  typedef struct packed {
    logic       kind;
    coord_t     start_x;
    coord_t     start_y;
    coord_t     end_x;
    coord_t     end_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } item_t;

  // One result item.
  typedef struct packed {
    coord_t     pixel_x;
    coord_t     pixel_y;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       visible;
    logic       blend;
    logic       last;
  } pixel_t;

  // Inclusive scissor box.
  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } scissor_t;

  // Stepper setup derived from a load item.
  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    len_t   abs_dx;
    len_t   abs_dy;
    dir_t   dir_x;
    dir_t   dir_y;
    logic   x_major;
    len_t   steps;
    rgba_t  colour;
  } setup_t;

endpackage

[src/slst_item_if.sv]
interface slst_item_if;
  logic                valid;
  logic                ready;
  slst_pkg::item_t     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/slst_pixel_if.sv]
interface slst_pixel_if;
  logic                valid;
  logic                ready;
  slst_pkg::pixel_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/slst_setup.sv]
module slst_setup (
  input  slst_pkg::item_t    item,
  input  slst_pkg::scissor_t scissor,
  output slst_pkg::setup_t   setup
);

  logic signed [12:0] dx;
  logic signed [12:0] dy;
  slst_pkg::len_t     adx_w;
  slst_pkg::len_t     ady_w;
  logic               reject;

  // Deltas need one extra bit so that the full coordinate span fits.
  assign dx = {item.end_x[11], item.end_x} - {item.start_x[11], item.start_x};
  assign dy = {item.end_y[11], item.end_y} - {item.start_y[11], item.start_y};

  // Magnitudes never exceed 4095, so they fit the length type.
  assign adx_w = dx[12] ? 12'(-dx) : dx[11:0];
  assign ady_w = dy[12] ? 12'(-dy) : dy[11:0];

  // Trivial reject: both ends on the outside of the same edge.
  assign reject =
      ($signed(item.start_x) < $signed(scissor.left) &&
       $signed(item.end_x)   < $signed(scissor.left)) ||
      ($signed(item.start_x) > $signed(slst_pkg::DISPLAY_W) &&
       $signed(item.end_x)   > $signed(slst_pkg::DISPLAY_W)) ||
      ($signed(item.start_y) < $signed(scissor.top) &&
       $signed(item.end_y)   < $signed(scissor.top)) ||
      ($signed(item.start_y) > $signed(slst_pkg::DISPLAY_H) &&
       $signed(item.end_y)   > $signed(slst_pkg::DISPLAY_H));

  always_comb begin
    setup.pos_x   = item.start_x;
    setup.pos_y   = item.start_y;
    setup.abs_dx  = adx_w;
    setup.abs_dy  = ady_w;
    setup.dir_x   = (dx == 13'sd0) ? slst_pkg::DIR_ZERO :
                    (dx[12] ? slst_pkg::DIR_NEG : slst_pkg::DIR_POS);
    setup.dir_y   = (dy == 13'sd0) ? slst_pkg::DIR_ZERO :
                    (dy[12] ? slst_pkg::DIR_NEG : slst_pkg::DIR_POS);
    setup.x_major = (adx_w >= ady_w);
    if (reject) begin
      setup.steps = '0;
    end else if (setup.x_major) begin
      setup.steps = adx_w;
    end else begin
      setup.steps = ady_w;
    end
    setup.colour.red   = item.red;
    setup.colour.green = item.green;
    setup.colour.blue  = item.blue;
    setup.colour.alpha = item.alpha;
  end

endmodule

[src/slst_stepper.sv]
module slst_stepper (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               step,
  input  slst_pkg::setup_t   setup,
  input  slst_pkg::scissor_t scissor,
  output slst_pkg::pixel_t   pixel
);

  slst_pkg::coord_t pos_x_r, pos_x_nxt;
  slst_pkg::coord_t pos_y_r, pos_y_nxt;
  slst_pkg::len_t   err_r, err_nxt;
  slst_pkg::len_t   steps_r, steps_nxt;
  slst_pkg::len_t   adx_r, adx_nxt;
  slst_pkg::len_t   ady_r, ady_nxt;
  slst_pkg::dir_t   dir_x_r, dir_x_nxt;
  slst_pkg::dir_t   dir_y_r, dir_y_nxt;
  logic             x_major_r, x_major_nxt;
  slst_pkg::rgba_t  colour_r, colour_nxt;

  slst_pkg::len_t   major_len;
  slst_pkg::len_t   minor_len;
  logic [12:0]      err_sum;
  logic             err_carry;
  slst_pkg::coord_t inc_x;
  slst_pkg::coord_t inc_y;
  slst_pkg::coord_t px;
  slst_pkg::coord_t py;
  logic             active;
  logic             in_box;

  assign active    = (steps_r != '0);
  assign major_len = x_major_r ? adx_r : ady_r;
  assign minor_len = x_major_r ? ady_r : adx_r;

  // Error accumulate and minor-axis correction ahead of the pixel.
  assign err_sum   = {1'b0, err_r} + {1'b0, minor_len};
  assign err_carry = (err_sum >= {1'b0, major_len});

  // Direction codes sign-extend straight to -1, 0 or +1.
  assign inc_x = pos_x_r + {{10{dir_x_r[1]}}, dir_x_r};
  assign inc_y = pos_y_r + {{10{dir_y_r[1]}}, dir_y_r};

  assign px = (!x_major_r && err_carry) ? inc_x : pos_x_r;
  assign py = (x_major_r && err_carry) ? inc_y : pos_y_r;

  assign in_box = !($signed(px) < $signed(scissor.left)  ||
                    $signed(px) > $signed(scissor.right) ||
                    $signed(py) < $signed(scissor.top)   ||
                    $signed(py) > $signed(scissor.bottom));

  // Result for the step item being taken this cycle.
  always_comb begin
    pixel = '0;
    if (active) begin
      pixel.pixel_x   = px;
      pixel.pixel_y   = py;
      pixel.out_red   = colour_r.red;
      pixel.out_green = colour_r.green;
      pixel.out_blue  = colour_r.blue;
      pixel.out_alpha = colour_r.alpha;
      pixel.visible   = in_box;
      pixel.blend     = (colour_r.alpha != slst_pkg::OPAQUE);
      pixel.last      = (steps_r == 12'd1);
    end else begin
      pixel.last = 1'b1;
    end
  end

  // Next stepper state: a load replaces the line, a step advances it.
  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    err_nxt     = err_r;
    steps_nxt   = steps_r;
    adx_nxt     = adx_r;
    ady_nxt     = ady_r;
    dir_x_nxt   = dir_x_r;
    dir_y_nxt   = dir_y_r;
    x_major_nxt = x_major_r;
    colour_nxt  = colour_r;
    if (load) begin
      pos_x_nxt   = setup.pos_x;
      pos_y_nxt   = setup.pos_y;
      err_nxt     = '0;
      steps_nxt   = setup.steps;
      adx_nxt     = setup.abs_dx;
      ady_nxt     = setup.abs_dy;
      dir_x_nxt   = setup.dir_x;
      dir_y_nxt   = setup.dir_y;
      x_major_nxt = setup.x_major;
      colour_nxt  = setup.colour;
    end else if (step && active) begin
      err_nxt   = err_carry ? 12'(err_sum - {1'b0, major_len}) : err_sum[11:0];
      pos_x_nxt = x_major_r ? inc_x : px;
      pos_y_nxt = x_major_r ? py : inc_y;
      steps_nxt = steps_r - 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      err_r     <= '0;
      steps_r   <= '0;
      adx_r     <= '0;
      ady_r     <= '0;
      dir_x_r   <= slst_pkg::DIR_ZERO;
      dir_y_r   <= slst_pkg::DIR_ZERO;
      x_major_r <= 1'b0;
      colour_r  <= '0;
    end else begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      err_r     <= err_nxt;
      steps_r   <= steps_nxt;
      adx_r     <= adx_nxt;
      ady_r     <= ady_nxt;
      dir_x_r   <= dir_x_nxt;
      dir_y_r   <= dir_y_nxt;
      x_major_r <= x_major_nxt;
      colour_r  <= colour_nxt;
    end
  end

endmodule

[src/scissored_line_stepper_core.sv]
// A step item's pixel goes through the input register, then the result register;
// a load item produces no result.
// Throughput: one item per cycle, except that a step item is held while a pixel waits.
// A load is taken even while a pixel waits at the output.
// Reset (synchronous, rst_n low) empties both registers, leaves no line
// active and returns the scissor box to 0, 0, 640, 480.
module scissored_line_stepper_core (
  input  logic               clk,
  input  logic               rst_n,
  slst_item_if.sink          in_item,
  slst_pixel_if.source       out_pixel,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  slst_pkg::scissor_t scissor_r, scissor_nxt;
  logic               in_vld_r, in_vld_nxt;
  slst_pkg::item_t    in_data_r, in_data_nxt;
  logic               out_vld_r, out_vld_nxt;
  slst_pkg::pixel_t   out_data_r, out_data_nxt;

  logic               advance;
  logic               is_load;
  logic               is_step;
  slst_pkg::setup_t   setup;
  slst_pkg::pixel_t   pixel;

  // Configuration writes.
  always_comb begin
    scissor_nxt = scissor_r;
    if (cfg_we) begin
      case (cfg_index)
        slst_pkg::CFG_SCISSOR_LEFT:   scissor_nxt.left   = cfg_data;
        slst_pkg::CFG_SCISSOR_TOP:    scissor_nxt.top    = cfg_data;
        slst_pkg::CFG_SCISSOR_RIGHT:  scissor_nxt.right  = cfg_data;
        slst_pkg::CFG_SCISSOR_BOTTOM: scissor_nxt.bottom = cfg_data;
        default: begin
          scissor_nxt = scissor_r;
        end
      endcase
    end
  end

  // The held item moves on when it is a load or the result slot frees up.
  assign is_load = in_vld_r && (in_data_r.kind == slst_pkg::KIND_LOAD);
  assign is_step = in_vld_r && (in_data_r.kind == slst_pkg::KIND_STEP);
  assign advance = is_load || (is_step && (!out_vld_r || out_pixel.ready));
  assign in_item.ready = !in_vld_r || advance;

  slst_setup u_setup (
    .item    (in_data_r),
    .scissor (scissor_r),
    .setup   (setup)
  );

  slst_stepper u_stepper (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (is_load),
    .step    (is_step && advance),
    .setup   (setup),
    .scissor (scissor_r),
    .pixel   (pixel)
  );

  // Input register and result register.
  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_data_nxt = in_data_r;
    if (in_item.ready) begin
      in_vld_nxt  = in_item.valid;
      in_data_nxt = in_item.data;
    end
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (is_step && advance) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = pixel;
    end else if (out_pixel.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scissor_r.left   <= slst_pkg::SCISSOR_LEFT_RST;
      scissor_r.top    <= slst_pkg::SCISSOR_TOP_RST;
      scissor_r.right  <= slst_pkg::SCISSOR_RIGHT_RST;
      scissor_r.bottom <= slst_pkg::SCISSOR_BOTTOM_RST;
      in_vld_r         <= 1'b0;
      out_vld_r        <= 1'b0;
    end else begin
      scissor_r <= scissor_nxt;
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_pixel.valid = out_vld_r;
  assign out_pixel.data  = out_data_r;

  // A step that moves on always lands in the result register.
  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (is_step && advance) |=> out_vld_r)
    else $error("step item advanced without a result");

  // A stalled result is never overwritten by a step.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_pixel.ready && is_step) |-> !advance)
    else $error("pending result overwritten");

  // A load never disturbs a pending result.
  a_load_keeps_out: assert property (@(posedge clk) disable iff (!rst_n)
    (is_load && out_vld_r && !out_pixel.ready) |=> (out_vld_r && $stable(out_data_r)))
    else $error("load disturbed a pending result");

  // A pixel ahead of its line end flags blending exactly when alpha is not opaque.
  a_blend_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_data_r.last) |->
      (out_data_r.blend == (out_data_r.out_alpha != slst_pkg::OPAQUE)))
    else $error("blend flag does not match alpha");

endmodule

[sim/tb_scissored_line_stepper_core.sv]
`timescale 1ns / 100ps

module tb_scissored_line_stepper_core;

  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_PHASES = 6;

  // One row of the directed table: the item and, where obvious, its pixel.
  typedef struct {
    slst_pkg::item_t  it;
    bit               typed;
    slst_pkg::pixel_t px;
  } vector_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  slst_item_if  item_ch ();
  slst_pixel_if pixel_ch ();

  scissored_line_stepper_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (item_ch),
    .out_pixel (pixel_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Scissor box and stepper state as the testbench tracks them.
  slst_pkg::scissor_t clip = '{slst_pkg::SCISSOR_LEFT_RST, slst_pkg::SCISSOR_TOP_RST,
                               slst_pkg::SCISSOR_RIGHT_RST, slst_pkg::SCISSOR_BOTTOM_RST};
  int                 cur_x = 0;
  int                 cur_y = 0;
  int                 err_sum = 0;
  int                 pix_left = 0;
  int                 span_x = 0;
  int                 span_y = 0;
  slst_pkg::dir_t     step_x = slst_pkg::DIR_ZERO;
  slst_pkg::dir_t     step_y = slst_pkg::DIR_ZERO;
  bit                 x_leads = 1'b0;
  slst_pkg::rgba_t    line_rgba = '0;

  slst_pkg::pixel_t   expected_pixels[$];

  // Pixel typed into the directed table for the item now on offer.
  bit                 typed_on = 1'b0;
  slst_pkg::pixel_t   typed_px = '0;

  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  bit                 hold_request = 1'b0;
  bit                 hold_rx = 1'b0;

  int                 items_sent = 0;
  int                 pixels_checked = 0;
  int                 pixel_mismatches = 0;
  int                 lines_loaded = 0;
  int                 lines_rejected = 0;
  int                 px_visible = 0;
  int                 px_blended = 0;
  int                 px_idle = 0;

  // Clock.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run limit.
  initial begin
    #2000000;
    $display("FAIL scissored_line_stepper_core");
    $finish;
  end

  function automatic slst_pkg::dir_t sign_code(input int d);
    return (d > 0) ? slst_pkg::DIR_POS : ((d < 0) ? slst_pkg::DIR_NEG : slst_pkg::DIR_ZERO);
  endfunction

  function automatic int dir_step(input slst_pkg::dir_t d);
    return (d == slst_pkg::DIR_POS) ? 1 : ((d == slst_pkg::DIR_NEG) ? -1 : 0);
  endfunction

  function automatic slst_pkg::coord_t clamp_coord(input int v);
    if (v < -2048) return slst_pkg::coord_t'(-2048);
    if (v > 2047) return slst_pkg::coord_t'(2047);
    return slst_pkg::coord_t'(v);
  endfunction

  function automatic slst_pkg::item_t rand_item();
    slst_pkg::item_t it;
    it.kind    = 1'($urandom_range(0, 1));
    it.start_x = slst_pkg::coord_t'($urandom);
    it.start_y = slst_pkg::coord_t'($urandom);
    it.end_x   = slst_pkg::coord_t'($urandom);
    it.end_y   = slst_pkg::coord_t'($urandom);
    it.red     = 8'($urandom);
    it.green   = 8'($urandom);
    it.blue    = 8'($urandom);
    it.alpha   = 8'($urandom);
    return it;
  endfunction

  function automatic slst_pkg::item_t step_item();
    slst_pkg::item_t it;
    it = rand_item();
    it.kind = slst_pkg::KIND_STEP;
    return it;
  endfunction

  function automatic slst_pkg::item_t load_item(input int sx, input int sy,
                                                input int ex, input int ey,
                                                input int r, input int g,
                                                input int b, input int a);
    slst_pkg::item_t it;
    it.kind    = slst_pkg::KIND_LOAD;
    it.start_x = clamp_coord(sx);
    it.start_y = clamp_coord(sy);
    it.end_x   = clamp_coord(ex);
    it.end_y   = clamp_coord(ey);
    it.red     = 8'(r);
    it.green   = 8'(g);
    it.blue    = 8'(b);
    it.alpha   = 8'(a);
    return it;
  endfunction

  // Advance the line tracker by one accepted item; a step queues its pixel.
  task automatic trace_item(input slst_pkg::item_t it, input bit use_typed,
                            input slst_pkg::pixel_t typed);
    int               sx;
    int               sy;
    int               ex;
    int               ey;
    slst_pkg::pixel_t px;
    if (it.kind == slst_pkg::KIND_LOAD) begin
      sx = int'(it.start_x);
      sy = int'(it.start_y);
      ex = int'(it.end_x);
      ey = int'(it.end_y);
      line_rgba = '{it.red, it.green, it.blue, it.alpha};
      cur_x = sx;
      cur_y = sy;
      err_sum = 0;
      step_x = sign_code(ex - sx);
      step_y = sign_code(ey - sy);
      span_x = (ex >= sx) ? ex - sx : sx - ex;
      span_y = (ey >= sy) ? ey - sy : sy - ey;
      x_leads = (span_x >= span_y);
      pix_left = x_leads ? span_x : span_y;
      lines_loaded++;
      // Trivial reject: both ends off the same side.
      if ((sx < clip.left && ex < clip.left) ||
          (sx > slst_pkg::DISPLAY_W && ex > slst_pkg::DISPLAY_W) ||
          (sy < clip.top && ey < clip.top) ||
          (sy > slst_pkg::DISPLAY_H && ey > slst_pkg::DISPLAY_H)) begin
        pix_left = 0;
        lines_rejected++;
      end
    end else begin
      px = '0;
      if (pix_left == 0) begin
        px.last = 1'b1;
        px_idle++;
      end else begin
        // Minor axis first, corrected before the pixel goes out.
        if (x_leads) begin
          err_sum += span_y;
          if (err_sum >= span_x) begin
            err_sum -= span_x;
            cur_y += dir_step(step_y);
          end
        end else begin
          err_sum += span_x;
          if (err_sum >= span_y) begin
            err_sum -= span_y;
            cur_x += dir_step(step_x);
          end
        end
        px.pixel_x   = slst_pkg::coord_t'(cur_x);
        px.pixel_y   = slst_pkg::coord_t'(cur_y);
        px.out_red   = line_rgba.red;
        px.out_green = line_rgba.green;
        px.out_blue  = line_rgba.blue;
        px.out_alpha = line_rgba.alpha;
        px.visible   = !(cur_x < clip.left || cur_x > clip.right ||
                         cur_y < clip.top || cur_y > clip.bottom);
        px.blend     = (line_rgba.alpha != slst_pkg::OPAQUE);
        // The major axis advances after the pixel.
        if (x_leads) cur_x += dir_step(step_x);
        else cur_y += dir_step(step_y);
        pix_left--;
        px.last = (pix_left == 0);
        if (px.visible) px_visible++;
        if (px.blend) px_blended++;
      end
      expected_pixels.push_back(use_typed ? typed : px);
    end
  endtask

  task automatic flag_mismatch(input string msg);
    pixel_mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_pixel(input slst_pkg::pixel_t got, input slst_pkg::pixel_t want);
    string tag;
    tag = $sformatf("pixel %0d", pixels_checked);
    if (got.pixel_x !== want.pixel_x)
      flag_mismatch($sformatf("%s x got %0d want %0d", tag, got.pixel_x, want.pixel_x));
    if (got.pixel_y !== want.pixel_y)
      flag_mismatch($sformatf("%s y got %0d want %0d", tag, got.pixel_y, want.pixel_y));
    if (got.out_red !== want.out_red)
      flag_mismatch($sformatf("%s red got %0d want %0d", tag, got.out_red, want.out_red));
    if (got.out_green !== want.out_green)
      flag_mismatch($sformatf("%s green got %0d want %0d", tag, got.out_green,
                              want.out_green));
    if (got.out_blue !== want.out_blue)
      flag_mismatch($sformatf("%s blue got %0d want %0d", tag, got.out_blue, want.out_blue));
    if (got.out_alpha !== want.out_alpha)
      flag_mismatch($sformatf("%s alpha got %0d want %0d", tag, got.out_alpha,
                              want.out_alpha));
    if (got.visible !== want.visible)
      flag_mismatch($sformatf("%s visible got %b want %b", tag, got.visible, want.visible));
    if (got.blend !== want.blend)
      flag_mismatch($sformatf("%s blend got %b want %b", tag, got.blend, want.blend));
    if (got.last !== want.last)
      flag_mismatch($sformatf("%s last got %b want %b", tag, got.last, want.last));
  endtask

  // Watch both channels at the rising edge; results are checked before new items count.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        if (expected_pixels.size() == 0) flag_mismatch("pixel transfer with nothing expected");
        else compare_pixel(pixel_ch.data, expected_pixels.pop_front());
        pixels_checked++;
      end
      if (item_ch.valid && item_ch.ready) trace_item(item_ch.data, typed_on, typed_px);
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    pixel_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      pixel_ch.ready = !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin
    wait (hold_request);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_rx = 1'b0;
  end

  // Offer one item, idling first at random, and return after its transfer.
  task automatic send_item(input slst_pkg::item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.data  = it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every pixel is back and any load has settled.
  task automatic drain_pixels();
    item_ch.valid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_box(input slst_pkg::scissor_t box);
    cfg_we = 1'b1;
    cfg_index = slst_pkg::CFG_SCISSOR_LEFT;
    cfg_data = box.left;
    @(negedge clk);
    cfg_index = slst_pkg::CFG_SCISSOR_TOP;
    cfg_data = box.top;
    @(negedge clk);
    cfg_index = slst_pkg::CFG_SCISSOR_RIGHT;
    cfg_data = box.right;
    @(negedge clk);
    cfg_index = slst_pkg::CFG_SCISSOR_BOTTOM;
    cfg_data = box.bottom;
    @(negedge clk);
    cfg_we = 1'b0;
    clip = box;
  endtask

  initial begin
    vector_row_t        directed[$];
    slst_pkg::scissor_t boxes[NUM_PHASES];
    int                 phase_items[NUM_PHASES];
    slst_pkg::pixel_t   idle_px;
    slst_pkg::pixel_t   first_px;
    slst_pkg::item_t    it;
    int                 sent;
    int                 g;
    int                 sx;
    int                 sy;
    int                 ex;
    int                 ey;
    int                 nsteps;

    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    cfg_we    = 1'b0;
    cfg_index = slst_pkg::CFG_SCISSOR_LEFT;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    idle_px = '0;
    idle_px.last = 1'b1;
    first_px = '{12'sd10, 12'sd20, 8'd255, 8'd0, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0};

    // Directed part under the reset scissor box.
    directed.push_back('{step_item(), 1'b1, idle_px});
    directed.push_back('{load_item(10, 20, 13, 20, 255, 0, 255, 255), 1'b0, '0});
    directed.push_back('{step_item(), 1'b1, first_px});
    directed.push_back('{step_item(), 1'b0, '0});
    directed.push_back('{step_item(), 1'b0, '0});
    directed.push_back('{step_item(), 1'b1, idle_px});
    // Zero-length line.
    directed.push_back('{load_item(5, 5, 5, 5, 0, 255, 0, 0), 1'b0, '0});
    directed.push_back('{step_item(), 1'b1, idle_px});
    // Rejected lines, one per side.
    directed.push_back('{load_item(-1, 5, -2048, 100, 1, 2, 3, 4), 1'b0, '0});
    directed.push_back('{step_item(), 1'b1, idle_px});
    directed.push_back('{load_item(641, 0, 2047, 10, 1, 2, 3, 255), 1'b0, '0});
    directed.push_back('{step_item(), 1'b1, idle_px});
    directed.push_back('{load_item(0, -1, 30, -2048, 9, 9, 9, 9), 1'b0, '0});
    directed.push_back('{step_item(), 1'b1, idle_px});
    directed.push_back('{load_item(5, 481, 0, 2047, 7, 7, 7, 255), 1'b0, '0});
    directed.push_back('{step_item(), 1'b1, idle_px});
    // Full-range diagonal, abandoned by the next load.
    directed.push_back('{load_item(-2048, -2048, 2047, 2047, 0, 0, 0, 0), 1'b0, '0});
    directed.push_back('{step_item(), 1'b0, '0});
    directed.push_back('{step_item(), 1'b0, '0});
    // Steep line going up and left, blended.
    directed.push_back('{load_item(300, 200, 297, 190, 1, 2, 3, 128), 1'b0, '0});
    directed.push_back('{step_item(), 1'b0, '0});
    directed.push_back('{step_item(), 1'b0, '0});
    directed.push_back('{step_item(), 1'b0, '0});
    // Line starting on the scissor corner.
    directed.push_back('{load_item(640, 480, 646, 486, 200, 100, 50, 255), 1'b0, '0});
    directed.push_back('{step_item(), 1'b0, '0});

    foreach (directed[i]) begin
      typed_on = directed[i].typed;
      typed_px = directed[i].px;
      send_item(directed[i].it);
    end
    typed_on = 1'b0;

    // Random phases: each has its own scissor box; the idle mix changes every two phases.
    boxes[0] = '{-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047};
    boxes[1] = '{12'sd10, 12'sd20, 12'sd600, 12'sd400};
    boxes[2] = '{12'sd300, 12'sd200, 12'sd100, 12'sd150};
    boxes[3] = '{slst_pkg::coord_t'($urandom_range(0, 840) - 100),
                 slst_pkg::coord_t'($urandom_range(0, 840) - 100),
                 slst_pkg::coord_t'($urandom_range(0, 840) - 100),
                 slst_pkg::coord_t'($urandom_range(0, 840) - 100)};
    boxes[4] = '{12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048};
    boxes[5] = '{slst_pkg::SCISSOR_LEFT_RST, slst_pkg::SCISSOR_TOP_RST,
                 slst_pkg::SCISSOR_RIGHT_RST, slst_pkg::SCISSOR_BOTTOM_RST};
    phase_items = '{260, 260, 220, 220, 80, 260};

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pixels();
      set_box(boxes[p]);
      if (p < 2) begin
        tx_idle_pct = 7;
        rx_idle_pct = 69;
      end else if (p < 4) begin
        tx_idle_pct = 69;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // Long output stall while the sender keeps going.
      if (p == 1) hold_request = 1'b1;

      sent = 0;
      while (sent < phase_items[p]) begin
        if ($urandom_range(0, 99) < 10) begin
          send_item(rand_item());
          sent++;
        end else begin
          // Mostly short lines near the display; a few anywhere or full length.
          g = $urandom_range(0, 99);
          sx = $urandom_range(0, 760) - 60;
          sy = $urandom_range(0, 600) - 60;
          if (g >= 70) begin
            sx = $urandom_range(0, 4095) - 2048;
            sy = $urandom_range(0, 4095) - 2048;
          end
          ex = sx + $urandom_range(0, 30) - 15;
          ey = sy + $urandom_range(0, 30) - 15;
          if (g >= 85) begin
            ex = $urandom_range(0, 4095) - 2048;
            ey = $urandom_range(0, 4095) - 2048;
          end
          it = load_item(sx, sy, ex, ey, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255),
                         ($urandom_range(0, 1) == 1) ? 255 : $urandom_range(0, 255));
          send_item(it);
          sent++;
          // Walk the line, sometimes past its end, sometimes abandoning it.
          if ($urandom_range(0, 9) == 0) nsteps = $urandom_range(0, pix_left);
          else nsteps = pix_left + $urandom_range(0, 1);
          if (nsteps > 40) nsteps = 40;
          repeat (nsteps) begin
            send_item(step_item());
            sent++;
          end
        end
      end
    end

    drain_pixels();
    repeat (8) @(negedge clk);

    $display("Drove %0d items (%0d line loads, %0d rejected)", items_sent, lines_loaded,
             lines_rejected);
    $display("over 6 scissor boxes and 3 idle mixes; checked %0d pixels: %0d visible, %0d %s",
             pixels_checked, px_visible, px_blended, "blended");
    $display("and %0d from an idle stepper.", px_idle);
    if (pixel_mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASS scissored_line_stepper_core");
    end else begin
      $display("FAIL scissored_line_stepper_core");
    end
    $finish;
  end

endmodule
